// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module of the edit distance engine.
// No dependencies; include this file by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold at the same edge as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ede_pkg.sv =====
// Package of the edit distance engine: field widths, command codes, defaults
// and the case folding function. No dependencies.
package ede_pkg;

    localparam int unsigned MaxLenDef = 32;
    localparam int unsigned ModeW     = 2;
    localparam int unsigned CharW     = 8;
    localparam int unsigned DistW     = 6;
    localparam int unsigned DistMax   = 63;

    typedef enum logic [ModeW-1:0] {
        MODE_LOAD_A  = 2'd0,
        MODE_LOAD_B  = 2'd1,
        MODE_COMPUTE = 2'd2
    } t_mode;

    // Maps ASCII upper case letters to lower case when folding is enabled.
    function automatic logic [CharW-1:0] fold_char(input logic [CharW-1:0] c,
                                                   input logic enable);
        logic [CharW-1:0] res;
        res = c;
        if (enable && c >= 8'h41 && c <= 8'h5A) begin
            res = c + 8'h20;
        end
        return res;
    endfunction

endpackage

// ===== src/ede_if.sv =====
// Channel interfaces of the edit distance engine: command items in, results out.
// Depends on ede_pkg for the field widths.
interface ede_in_if;
    import ede_pkg::*;
    logic             valid;
    logic             ready;
    logic [ModeW-1:0] mode;
    logic [CharW-1:0] char_code;
    modport source (output valid, output mode, output char_code, input ready);
    modport sink (input valid, input mode, input char_code, output ready);
endinterface

interface ede_out_if;
    import ede_pkg::*;
    logic             valid;
    logic             ready;
    logic [DistW-1:0] distance;
    logic             too_long;
    modport source (output valid, output distance, output too_long, input ready);
    modport sink (input valid, input distance, input too_long, output ready);
endinterface

// ===== src/edit_distance_engine_unit.sv =====
// Top level of the edit distance engine.
// Depends on ede_pkg, ede_if and ede_ram.
//
// The engine computes the Levenshtein distance (insert, delete and substitute
// each cost one) between two byte strings of up to MAX_LEN bytes. A transaction
// with mode MODE_LOAD_A appends char_code to the first string and one with
// MODE_LOAD_B appends it to the second; a byte that arrives when its string is
// full is dropped and the too_long flag of the next result is set. A
// transaction with MODE_COMPUTE runs the dynamic program, delivers one result
// (distance saturated to 63, too_long) and then empties both strings and the
// flag for the next pair. Mode 3 is accepted and ignored. Loads are accepted
// back to back, even while an earlier result waits on the output register. A
// compute keeps the input stalled while it initializes each working row entry
// in ST_INIT, then opens each row in ST_ROW_A and ST_ROW_B and works one cell
// per cycle in ST_CELL, a pace set by the single read port of the working row
// memory, and last hands the result over in ST_DONE. Both strings share one RAM
// and the working row lives in a second RAM; neither needs a clearing pass after
// reset. The fold_case register (reset 1) folds A-Z to a-z at compare time and
// is written by i_cfg_we with i_cfg_data.
module edit_distance_engine_unit #(
    parameter int unsigned MAX_LEN = ede_pkg::MaxLenDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ede_in_if.sink    i_item,
    ede_out_if.source o_result,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data
);
    import ede_pkg::*;

    // Index width of one string, count width (holds MAX_LEN itself).
    localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned CW = $clog2(MAX_LEN + 1);
    localparam int unsigned XW = CW + DistW;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_INIT  = 6'b000010,
        ST_ROW_A = 6'b000100,
        ST_ROW_B = 6'b001000,
        ST_CELL  = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_len_a, n_len_a;
    logic [CW-1:0]    r_len_b, n_len_b;
    logic             r_ovf, n_ovf;
    logic             r_fold;
    logic [CW-1:0]    r_i, n_i;
    logic [CW-1:0]    r_j, n_j;
    logic [CW-1:0]    r_left, n_left;
    logic [CW-1:0]    r_diag, n_diag;
    logic [CharW-1:0] r_a, n_a;
    logic             r_out_valid, n_out_valid;
    logic [DistW-1:0] r_out_dist, n_out_dist;
    logic             r_out_long, n_out_long;

    // Text RAM: the first string in the lower half, the second in the upper.
    logic             text_we;
    logic [IW:0]      text_waddr;
    logic [IW:0]      text_raddr;
    logic [CharW-1:0] text_rdata;

    // Working row RAM.
    logic             row_we;
    logic [CW-1:0]    row_waddr;
    logic [CW-1:0]    row_wdata;
    logic [CW-1:0]    row_raddr;
    logic [CW-1:0]    row_rdata;

    logic             in_acc;
    logic [CW:0]      cand_up;
    logic [CW:0]      cand_left;
    logic [CW:0]      cand_diag;
    logic [CW:0]      cand_min;
    logic [XW-1:0]    left_ext;
    logic [IW-1:0]    row_prev;

    ede_ram #(.WIDTH(CharW), .DEPTH(2 * (1 << IW))) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (text_we),
        .i_waddr (text_waddr),
        .i_wdata (i_item.char_code),
        .i_raddr (text_raddr),
        .o_rdata (text_rdata)
    );

    ede_ram #(.WIDTH(CW), .DEPTH(MAX_LEN + 1)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    assign i_item.ready      = (r_state == ST_IDLE);
    assign in_acc            = i_item.valid && i_item.ready;
    assign o_result.valid    = r_out_valid;
    assign o_result.distance = r_out_dist;
    assign o_result.too_long = r_out_long;

    // One cell of the recurrence: the smallest of the entry above plus one,
    // the entry to the left plus one, and the diagonal plus the mismatch cost.
    always_comb begin
        cand_up   = {1'b0, row_rdata} + 1'b1;
        cand_left = {1'b0, r_left} + 1'b1;
        cand_diag = {1'b0, r_diag}
                  + ((r_a != fold_char(text_rdata, r_fold)) ? 1'b1 : 1'b0);
        cand_min  = (cand_up < cand_left) ? cand_up : cand_left;
        if (cand_diag < cand_min) begin
            cand_min = cand_diag;
        end
    end

    assign left_ext = XW'(r_left);
    assign row_prev = IW'(r_i - 1'b1);

    always_comb begin
        n_state     = r_state;
        n_len_a     = r_len_a;
        n_len_b     = r_len_b;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_left      = r_left;
        n_diag      = r_diag;
        n_a         = r_a;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_dist  = r_out_dist;
        n_out_long  = r_out_long;
        text_we     = 1'b0;
        text_waddr  = '0;
        text_raddr  = '0;
        row_we      = 1'b0;
        row_waddr   = '0;
        row_wdata   = '0;
        row_raddr   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_item.mode)
                        MODE_LOAD_A: begin
                            if (r_len_a < CW'(MAX_LEN)) begin
                                text_we    = 1'b1;
                                text_waddr = {1'b0, r_len_a[IW-1:0]};
                                n_len_a    = r_len_a + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        MODE_LOAD_B: begin
                            if (r_len_b < CW'(MAX_LEN)) begin
                                text_we    = 1'b1;
                                text_waddr = {1'b1, r_len_b[IW-1:0]};
                                n_len_b    = r_len_b + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        MODE_COMPUTE: begin
                            n_j     = '0;
                            n_state = ST_INIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_INIT: begin
                // Row zero holds the distance from the empty prefix.
                row_we    = 1'b1;
                row_waddr = r_j;
                row_wdata = r_j;
                if (r_j == r_len_b) begin
                    n_left  = r_len_b;
                    n_i     = CW'(1);
                    n_state = (r_len_a == '0) ? ST_DONE : ST_ROW_A;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_ROW_A: begin
                text_raddr = {1'b0, row_prev};
                row_raddr  = '0;
                n_state    = ST_ROW_B;
            end
            ST_ROW_B: begin
                n_a       = fold_char(text_rdata, r_fold);
                n_diag    = row_rdata;
                row_we    = 1'b1;
                row_waddr = '0;
                row_wdata = r_i;
                n_left    = r_i;
                if (r_len_b == '0) begin
                    if (r_i == r_len_a) begin
                        n_state = ST_DONE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_ROW_A;
                    end
                end else begin
                    text_raddr = {1'b1, IW'(0)};
                    row_raddr  = CW'(1);
                    n_j        = CW'(1);
                    n_state    = ST_CELL;
                end
            end
            ST_CELL: begin
                row_we    = 1'b1;
                row_waddr = r_j;
                row_wdata = cand_min[CW-1:0];
                n_left    = cand_min[CW-1:0];
                n_diag    = row_rdata;
                if (r_j == r_len_b) begin
                    if (r_i == r_len_a) begin
                        n_state = ST_DONE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_ROW_A;
                    end
                end else begin
                    // The next cell reads an entry that no write of this
                    // cycle touches, so no forwarding is needed.
                    text_raddr = {1'b1, r_j[IW-1:0]};
                    row_raddr  = r_j + 1'b1;
                    n_j        = r_j + 1'b1;
                end
            end
            ST_DONE: begin
                // Wait here if the previous result has not been taken yet.
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_dist  = (left_ext > XW'(DistMax)) ? DistW'(DistMax)
                                                            : left_ext[DistW-1:0];
                    n_out_long  = r_ovf;
                    n_len_a     = '0;
                    n_len_b     = '0;
                    n_ovf       = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_ovf       <= 1'b0;
            r_fold      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len_a     <= n_len_a;
            r_len_b     <= n_len_b;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_fold <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_left     <= n_left;
        r_diag     <= n_diag;
        r_a        <= n_a;
        r_out_dist <= n_out_dist;
        r_out_long <= n_out_long;
    end

endmodule

// ===== src/ede_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module ede_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/ede_checker.sv =====
// Port level checks of the edit distance engine and the bind that attaches them.
// Depends on ede_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ede_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic [ede_pkg::ModeW-1:0] i_in_mode,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [ede_pkg::DistW-1:0] i_out_distance,
    input logic                    i_out_too_long
);
    import ede_pkg::*;

    logic in_cmp;

    assign in_cmp = i_in_valid && i_in_ready && (i_in_mode == MODE_COMPUTE);

    // A result waiting on the output stays offered until it is taken.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped before it was taken")

    // A waiting result keeps its payload.
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_distance) && $stable(i_out_too_long), "result changed while stalled")

    // A compute transaction stalls the input on the following cycle.
    `ASSERT_NEXT(a_cmp_stall, i_clk, i_rst_n, in_cmp, !i_in_ready, "input ready right after a compute")

    // A compute cannot produce its result on the very next cycle.
    `ASSERT_NEXT(a_cmp_latency, i_clk, i_rst_n, in_cmp && !i_out_valid, !i_out_valid, "result appeared too early")

endmodule

bind edit_distance_engine_unit ede_checker u_ede_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_in_mode      (i_item.mode),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_out_distance (o_result.distance),
    .i_out_too_long (o_result.too_long)
);

// ===== tb/edit_distance_check_pkg.sv =====
// Scoreboard for the edit distance engine testbench: expected-result prediction
// and result checking. Depends on ede_pkg for widths and command codes.
package edit_distance_check_pkg;
    import ede_pkg::*;

    // Command code that the engine accepts and ignores.
    localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

    typedef logic [CharW-1:0] t_text[$];

    typedef struct packed {
        logic [DistW-1:0] distance;
        logic             too_long;
    } t_result;

    class edit_distance_scoreboard;
        logic [CharW-1:0] first_text[MaxLenDef];
        logic [CharW-1:0] second_text[MaxLenDef];
        int unsigned      first_count;
        int unsigned      second_count;
        bit               overflow_seen;
        bit               fold_case;
        t_result          expected_q[$];
        int unsigned      errors;
        int unsigned      items_taken;
        int unsigned      ignored;
        int unsigned      compares;
        int unsigned      overflowed;

        function new();
            first_count   = 0;
            second_count  = 0;
            overflow_seen = 1'b0;
            fold_case     = 1'b1;
            errors        = 0;
            items_taken   = 0;
            ignored       = 0;
            compares      = 0;
            overflowed    = 0;
        endfunction

        function void set_fold_case(bit value);
            fold_case = value;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Upper case ASCII letters compare equal to lower case ones when folding.
        function logic [CharW-1:0] fold_byte(logic [CharW-1:0] c);
            if (fold_case && c >= 8'h41 && c <= 8'h5A) begin
                return c + 8'h20;
            end
            return c;
        endfunction

        // Row-by-row Levenshtein distance over the stored strings.
        function int unsigned levenshtein();
            int unsigned      row[MaxLenDef+1];
            int unsigned      diag;
            int unsigned      up;
            int unsigned      sub;
            int unsigned      best;
            logic [CharW-1:0] a;
            for (int unsigned j = 0; j <= second_count; j++) begin
                row[j] = j;
            end
            for (int unsigned i = 1; i <= first_count; i++) begin
                diag   = row[0];
                a      = fold_byte(first_text[i-1]);
                row[0] = i;
                for (int unsigned j = 1; j <= second_count; j++) begin
                    up   = row[j];
                    sub  = diag + ((a == fold_byte(second_text[j-1])) ? 0 : 1);
                    best = up + 1;
                    if (row[j-1] + 1 < best) begin
                        best = row[j-1] + 1;
                    end
                    if (sub < best) begin
                        best = sub;
                    end
                    row[j] = best;
                    diag   = up;
                end
            end
            return (row[second_count] > DistMax) ? DistMax : row[second_count];
        endfunction

        // Called for every accepted command transaction.
        function void note_item(logic [ModeW-1:0] mode, logic [CharW-1:0] code);
            t_result res;
            case (mode)
                MODE_LOAD_A: begin
                    items_taken++;
                    if (first_count < MaxLenDef) begin
                        first_text[first_count] = code;
                        first_count++;
                    end else begin
                        overflow_seen = 1'b1;
                    end
                end
                MODE_LOAD_B: begin
                    items_taken++;
                    if (second_count < MaxLenDef) begin
                        second_text[second_count] = code;
                        second_count++;
                    end else begin
                        overflow_seen = 1'b1;
                    end
                end
                MODE_COMPUTE: begin
                    items_taken++;
                    res.distance = DistW'(levenshtein());
                    res.too_long = overflow_seen;
                    if (overflow_seen) begin
                        overflowed++;
                    end
                    expected_q = {expected_q, res};
                    first_count   = 0;
                    second_count  = 0;
                    overflow_seen = 1'b0;
                end
                default: begin
                    ignored++;
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // Called for every accepted result transaction.
        task check_result(logic [DistW-1:0] distance, logic too_long);
            t_result want;
            compares++;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d (distance %0d, too_long %0b) with none expected",
                                 compares, distance, too_long));
                return;
            end
            want = expected_q.pop_front();
            if (distance !== want.distance) begin
                report($sformatf("result %0d: distance %0d, expected %0d",
                                 compares, distance, want.distance));
            end
            if (too_long !== want.too_long) begin
                report($sformatf("result %0d: too_long %0b, expected %0b",
                                 compares, too_long, want.too_long));
            end
        endtask

        task finish_check();
            if (expected_q.size() > 0) begin
                report($sformatf("%0d expected results never arrived", expected_q.size()));
            end
        endtask
    endclass

endpackage

// ===== tb/tb_edit_distance_engine_unit.sv =====
// Top-level testbench of edit_distance_engine_unit: directed and random string
// pairs with random idling on both channels. Depends on ede_pkg, ede_if and
// edit_distance_check_pkg.
module tb_edit_distance_engine_unit;
    import ede_pkg::*;
    import edit_distance_check_pkg::*;

    // A compute of two full strings stalls the input through the whole dynamic program,
    // and the result may then wait out a receiver stall and a sender gap. The
    // watchdog allows well more than all of that before it declares the engine hung.
    localparam int unsigned StallLimit  = 6000;
    // Cycles to keep watching after the last expected result, long enough for
    // one full-size compute to produce a stray result.
    localparam int unsigned DrainCycles = 1200;
    // Random transactions per fold_case phase; eight phases in all.
    localparam int unsigned PhaseItems  = 180;
    localparam int unsigned PhaseCount  = 8;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_data;

    ede_in_if  item_if ();
    ede_out_if result_if ();

    edit_distance_scoreboard scoreboard = new();

    // Idling state of each side: a burst of draws either all without wait
    // (quiet) or each with a random wait.
    int unsigned in_left   = 0;
    bit          in_quiet  = 1'b0;
    int unsigned out_left  = 0;
    bit          out_quiet = 1'b0;
    int unsigned quiet_cycles = 0;

    edit_distance_engine_unit #(
        .MAX_LEN(MaxLenDef)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_if),
        .o_result  (result_if),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Draws the wait before the next transaction on one side. Every so often a
    // new burst starts, and one burst in four has no waits at all, so that the
    // engine also sees back-to-back traffic.
    task automatic draw_wait(inout int unsigned left, inout bit quiet,
                             output int unsigned cycles);
        if (left == 0) begin
            left  = $urandom_range(8, 40);
            quiet = ($urandom_range(0, 3) == 0);
        end
        left--;
        cycles = quiet ? 0 : $urandom_range(0, 7);
    endtask

    // Presents one command and waits until the engine takes it. The valid line
    // is only lowered when a gap is drawn; with no gap it stays high from the
    // previous transaction and just carries the new payload.
    task automatic send_item(input logic [ModeW-1:0] mode, input logic [CharW-1:0] code);
        int unsigned gap;
        draw_wait(in_left, in_quiet, gap);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid     <= 1'b1;
        item_if.mode      <= mode;
        item_if.char_code <= code;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        scoreboard.note_item(mode, code);
    endtask

    // Stops sending and waits until every expected result has come out. Loads
    // produce no result, so the task then lets the clock run on to let the last
    // one land before the register may change.
    task automatic wait_idle();
        item_if.valid <= 1'b0;
        while (scoreboard.pending() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_fold_case(input bit value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        scoreboard.set_fold_case(value);
    endtask

    // Mostly short letters from a small alphabet in both cases, so that
    // matches and case folding matter; some from all 26 letters, the rest arbitrary bytes.
    function automatic logic [CharW-1:0] random_char();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 4));
        end else if (pick < 8) begin
            return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
        end
        return 8'($urandom);
    endfunction

    // Builds one pair of strings. Most pairs are a short string and a copy of
    // it with a few edits and case flips, which gives small, meaningful
    // distances. Some pairs are unrelated, some run near or past the string length
    // to set too_long, and a few fill both strings completely or nearly.
    task automatic build_pair(output t_text first, output t_text second);
        int unsigned sel;
        int unsigned n1;
        int unsigned n2;
        int unsigned edits;
        int unsigned op;
        first  = {};
        second = {};
        sel    = $urandom_range(0, 99);
        if (sel < 75) begin
            n1 = $urandom_range(0, 8);
            repeat (n1) first = {first, random_char()};
            second = first;
            for (edits = $urandom_range(0, 3); edits > 0; edits--) begin
                op = $urandom_range(0, 2);
                if (op == 0 && second.size() > 0) begin
                    second[$urandom_range(0, second.size() - 1)] = random_char();
                end else if (op == 1) begin
                    second.insert($urandom_range(0, second.size()), random_char());
                end else if (second.size() > 0) begin
                    second.delete($urandom_range(0, second.size() - 1));
                end
            end
            foreach (second[p]) begin
                if ((second[p] | 8'h20) >= 8'h61 && (second[p] | 8'h20) <= 8'h7A &&
                    $urandom_range(0, 3) == 0) begin
                    second[p] = second[p] ^ 8'h20;
                end
            end
            return;
        end else if (sel < 88) begin
            n1 = $urandom_range(0, 16);
            n2 = $urandom_range(0, 16);
        end else if (sel < 95) begin
            n1 = $urandom_range(MaxLenDef - 2, MaxLenDef + 8);
            n2 = $urandom_range(0, MaxLenDef + 8);
        end else begin
            n1 = $urandom_range(MaxLenDef - 4, MaxLenDef);
            n2 = $urandom_range(MaxLenDef - 4, MaxLenDef);
        end
        if ($urandom_range(0, 1)) begin
            {n1, n2} = {n2, n1};
        end
        repeat (n1) first = {first, random_char()};
        repeat (n2) second = {second, random_char()};
    endtask

    // Loads a pair with the two strings interleaved at random, sprinkles in
    // ignored commands now and then, and ends with a compute.
    task automatic run_pair(input t_text first, input t_text second);
        int unsigned ia;
        int unsigned ib;
        ia = 0;
        ib = 0;
        while (ia < first.size() || ib < second.size()) begin
            if ($urandom_range(0, 15) == 0) begin
                send_item(MODE_UNUSED, 8'($urandom));
            end
            if (ib >= second.size() || (ia < first.size() && $urandom_range(0, 1))) begin
                send_item(MODE_LOAD_A, first[ia]);
                ia++;
            end else begin
                send_item(MODE_LOAD_B, second[ib]);
                ib++;
            end
        end
        send_item(MODE_COMPUTE, 8'($urandom));
    endtask

    // Result side: stall for a drawn number of cycles, then hold ready high
    // until a result transaction completes, and check it.
    initial begin : result_sink
        int unsigned stall;
        result_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            draw_wait(out_left, out_quiet, stall);
            if (stall > 0) begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge i_clk); while (result_if.valid !== 1'b1);
            scoreboard.check_result(result_if.distance, result_if.too_long);
        end
    end

    // Ends the run if no transaction completes on either channel for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= StallLimit) begin
                $display("Watchdog: no transaction for %0d cycles", StallLimit);
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        t_text       first;
        t_text       second;
        int unsigned phase_end;
        item_if.valid     <= 1'b0;
        item_if.mode      <= MODE_LOAD_A;
        item_if.char_code <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_data        <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Both strings empty: the distance is zero.
        send_item(MODE_COMPUTE, 8'hA5);

        // Extreme byte values in the first string only, with an ignored
        // command in between; the distance is the length of the first string.
        send_item(MODE_LOAD_A, 8'h00);
        send_item(MODE_UNUSED, 8'hFF);
        send_item(MODE_LOAD_A, 8'hFF);
        send_item(MODE_COMPUTE, 8'h00);

        // Second string only.
        send_item(MODE_LOAD_B, 8'h5A);
        send_item(MODE_LOAD_B, 8'h7F);
        send_item(MODE_COMPUTE, 8'hFF);

        // The bytes just outside A-Z and a-z must not be folded together.
        send_item(MODE_LOAD_A, 8'h40);
        send_item(MODE_LOAD_A, 8'h5B);
        send_item(MODE_LOAD_B, 8'h60);
        send_item(MODE_LOAD_B, 8'h7B);
        send_item(MODE_COMPUTE, 8'h00);

        // Mixed-case strings loaded while folding is on, then folding is
        // switched off before the compute: folding acts at compare time, so
        // the letters must now differ.
        send_item(MODE_LOAD_A, 8'h41);
        send_item(MODE_LOAD_A, 8'h7A);
        send_item(MODE_LOAD_B, 8'h61);
        send_item(MODE_LOAD_B, 8'h5A);
        wait_idle();
        write_fold_case(1'b0);
        send_item(MODE_COMPUTE, 8'h3C);

        // Random pairs, with fold_case alternating between its two values
        // from one phase to the next.
        for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
            wait_idle();
            write_fold_case(phase[0] == 1'b0);
            phase_end = scoreboard.items_taken + PhaseItems;
            while (scoreboard.items_taken < phase_end) begin
                build_pair(first, second);
                run_pair(first, second);
            end
        end

        wait_idle();
        repeat (DrainCycles) @(posedge i_clk);
        scoreboard.finish_check();

        $display("Covered %0d load and compute transactions plus %0d ignored commands.",
                 scoreboard.items_taken, scoreboard.ignored);
        $display("Checked %0d distances, %0d of them with truncated strings; %0d mismatches.",
                 scoreboard.compares, scoreboard.overflowed, scoreboard.errors);
        if (scoreboard.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/ede_pkg.sv
src/ede_if.sv
src/ede_ram.sv
src/edit_distance_engine_unit.sv
src/ede_checker.sv
tb/edit_distance_check_pkg.sv
tb/tb_edit_distance_engine_unit.sv
